### rtl/ngv_pkg.sv
// Shared constants, types and kind tables of the node graph validator.
package ngv_pkg;
  localparam int NODE_CAP   = 256;
  localparam int IDX_W      = $clog2(NODE_CAP);
  localparam int CNT_W      = $clog2(NODE_CAP + 1);
  localparam int PIN_SLOTS  = 5;
  localparam int KIND_COUNT = 14;
  localparam int ID_W       = 30;
  localparam int PIN_W      = 3;
  localparam int KIND_W     = 4;
  localparam int CMD_W      = 2;
  localparam int ERR_W      = 3;
  localparam int TOTAL_W    = 9;
  localparam int WID_W      = 2;
  localparam int DEG_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NODE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LINK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_ANALYZE = 2'd3;

  localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY = 3'd1;
  localparam logic [ERR_W-1:0] ERR_BAD_NODE = 3'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_LINK = 3'd3;
  localparam logic [ERR_W-1:0] ERR_CYCLE    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_MISMATCH = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_REP_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_FROM_ID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_FROM_PIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_TO_ID    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_TO_PIN   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_OUTPUT   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_TEXTURE  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_COLOR    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_TEXCOORD = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LERP     = 4'd9;

  localparam logic [WID_W-1:0] WID_SCALAR = 2'd1;
  localparam logic [WID_W-1:0] WID_COORD  = 2'd2;
  localparam logic [WID_W-1:0] WID_COLOR  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
  } node_t;

  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  src;
    logic [PIN_W-1:0]  chan;
  } slot_t;

  typedef slot_t [PIN_SLOTS-1:0] row_t;

  function automatic logic [PIN_W-1:0] kind_inputs(input logic [KIND_W-1:0] k);
    logic [PIN_W-1:0] r;
    case (k) inside
      4'd0:           r = 3'd5;
      4'd1:           r = 3'd1;
      [4'd2:4'd4]:    r = 3'd0;
      [4'd5:4'd8]:    r = 3'd2;
      4'd9:           r = 3'd3;
      4'd10, 4'd11:   r = 3'd1;
      4'd12:          r = 3'd2;
      4'd13:          r = 3'd1;
      default:        r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PIN_W-1:0] kind_outputs(input logic [KIND_W-1:0] k);
    logic [PIN_W-1:0] r;
    case (k) inside
      4'd0:           r = 3'd0;
      4'd1:           r = 3'd6;
      4'd2:           r = 3'd1;
      4'd3:           r = 3'd4;
      4'd4:           r = 3'd3;
      [4'd5:4'd13]:   r = 3'd1;
      default:        r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic pin_ok(input logic [KIND_W-1:0] k, input logic [PIN_W-1:0] p,
                                  input logic [WID_W-1:0] w);
    logic [WID_W-1:0] expected;
    logic ok;
    expected = (p == 3'd0 || p == 3'd3) ? WID_COLOR : WID_SCALAR;
    ok = 1'b1;
    if (k == KIND_OUTPUT) begin
      ok = (w == expected) || (w == WID_SCALAR && p != 3'd3);
    end else if (k == KIND_TEXTURE) begin
      ok = (w == WID_COORD);
    end else if (k == KIND_LERP && p == 3'd2) begin
      ok = (w == WID_SCALAR);
    end
    return ok;
  endfunction

  function automatic slot_t slot_at(input row_t r, input logic [PIN_W-1:0] p);
    slot_t s;
    case (p)
      3'd0:    s = r[0];
      3'd1:    s = r[1];
      3'd2:    s = r[2];
      3'd3:    s = r[3];
      3'd4:    s = r[4];
      default: s = '0;
    endcase
    return s;
  endfunction
endpackage

### rtl/ngv_if.sv
// Command and result channel interfaces of the node graph validator.
interface ngv_cmd_if;
  import ngv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   node_id;
  logic [KIND_W-1:0] node_kind;
  logic [ID_W-1:0]   link_from_id;
  logic [PIN_W-1:0]  link_from_pin;
  logic [ID_W-1:0]   link_to_id;
  logic [PIN_W-1:0]  link_to_pin;
  modport source (output valid, command, node_id, node_kind, link_from_id, link_from_pin,
                  link_to_id, link_to_pin, input ready);
  modport sink (input valid, command, node_id, node_kind, link_from_id, link_from_pin,
                link_to_id, link_to_pin, output ready);
endinterface

interface ngv_res_if;
  import ngv_pkg::*;
  logic               valid;
  logic               ready;
  logic               analysis_done;
  logic               graph_valid;
  logic [ERR_W-1:0]   error_code;
  logic [TOTAL_W-1:0] node_total;
  modport source (output valid, analysis_done, graph_valid, error_code, node_total,
                  input ready);
  modport sink (input valid, analysis_done, graph_valid, error_code, node_total,
                output ready);
endinterface

### rtl/ngv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ngv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/node_graph_validator_top.sv
// Node graph validator: load checks, Kahn sort, width inference and pin type check.
// Clear skips the id search. A node or link load runs a linear id search over the
// loaded entries of the node table; a command rejected at once skips the search.
// Analyze time is dominated by the in-degree scan over all loaded nodes per sorted node.
// One command in flight at a time; a result waits in the output register.
// Reset empties the graph and clears the error; tables need no clearing pass.
module node_graph_validator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [ngv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ngv_pkg::CFG_DATA_W-1:0] cfg_data,
  ngv_cmd_if.sink                        cmd,
  ngv_res_if.source                      result
);
  import ngv_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_NODE_END, S_LINK_CHK, S_LINK_WR, S_REP_CHK,
    S_INIT_RD, S_INIT_PR, S_POP, S_POP_W, S_CUR_RD, S_CUR_PR, S_W_SL, S_W_AC,
    S_SCAN_RD, S_SCAN_PR, S_CHK_RD, S_CHK_LD, S_C_SL, S_C_AC, S_RESP
  } state_t;

  state_t state;

  logic              rep_enable;
  logic [ID_W-1:0]   rep_from_id;
  logic [PIN_W-1:0]  rep_from_pin;
  logic [ID_W-1:0]   rep_to_id;
  logic [PIN_W-1:0]  rep_to_pin;

  logic [CNT_W-1:0]  loaded;
  logic [ERR_W-1:0]  ferr;
  logic [CMD_W-1:0]  opcode;
  logic [ID_W-1:0]   key_a;
  logic [ID_W-1:0]   key_b;
  logic [PIN_W-1:0]  pin_a;
  logic [PIN_W-1:0]  pin_b;
  logic [KIND_W-1:0] new_kind;
  logic [CNT_W-1:0]  idx;
  logic              found_a;
  logic              found_b;
  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  idx_b;
  logic [KIND_W-1:0] kind_a;
  logic [KIND_W-1:0] kind_b;
  logic              ovr;
  logic [IDX_W-1:0]  ovr_node;
  logic [PIN_W-1:0]  ovr_pin;
  logic [IDX_W-1:0]  ovr_src;
  logic [PIN_W-1:0]  ovr_chan;
  logic [CNT_W-1:0]  head;
  logic [CNT_W-1:0]  tail;
  logic [IDX_W-1:0]  cur;
  logic [KIND_W-1:0] cur_kind;
  row_t              row;
  logic [PIN_W-1:0]  pin;
  logic [WID_W-1:0]  wacc;
  logic              done;

  logic               out_valid;
  logic               out_done;
  logic               out_gv;
  logic [ERR_W-1:0]   out_err;
  logic [TOTAL_W-1:0] out_total;

  logic              node_we;
  logic [IDX_W-1:0]  node_waddr;
  node_t             node_wdata;
  logic [IDX_W-1:0]  node_raddr;
  node_t             node_rdata;
  logic              link_we;
  logic [IDX_W-1:0]  link_waddr;
  row_t              link_wdata;
  logic [IDX_W-1:0]  link_raddr;
  row_t              link_rdata;
  logic              deg_we;
  logic [IDX_W-1:0]  deg_waddr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [IDX_W-1:0]  deg_raddr;
  logic [DEG_W-1:0]  deg_rdata;
  logic              wid_we;
  logic [IDX_W-1:0]  wid_waddr;
  logic [WID_W-1:0]  wid_wdata;
  logic [IDX_W-1:0]  wid_raddr;
  logic [WID_W-1:0]  wid_rdata;
  logic              que_we;
  logic [IDX_W-1:0]  que_waddr;
  logic [IDX_W-1:0]  que_wdata;
  logic [IDX_W-1:0]  que_raddr;
  logic [IDX_W-1:0]  que_rdata;

  logic              link_ok;
  logic [IDX_W-1:0]  eff_idx;
  row_t              row_eff;
  row_t              row_new;
  logic [DEG_W-1:0]  deg_cnt;
  logic [DEG_W-1:0]  match_cnt;
  logic [DEG_W-1:0]  deg_left;
  slot_t             cur_slot;
  logic              out_free;

  ngv_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_CAP)) u_node_ram (
    .clk, .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );
  ngv_ram #(.WIDTH($bits(row_t)), .DEPTH(NODE_CAP)) u_link_ram (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rdata)
  );
  ngv_ram #(.WIDTH(DEG_W), .DEPTH(NODE_CAP)) u_deg_ram (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata)
  );
  ngv_ram #(.WIDTH(WID_W), .DEPTH(NODE_CAP)) u_wid_ram (
    .clk, .we(wid_we), .waddr(wid_waddr), .wdata(wid_wdata),
    .raddr(wid_raddr), .rdata(wid_rdata)
  );
  ngv_ram #(.WIDTH(IDX_W), .DEPTH(NODE_CAP)) u_que_ram (
    .clk, .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
    .raddr(que_raddr), .rdata(que_rdata)
  );

  assign cmd.ready            = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.analysis_done = out_done;
  assign result.graph_valid   = out_gv;
  assign result.error_code    = out_err;
  assign result.node_total    = out_total;
  assign out_free             = !out_valid || result.ready;

  always_comb begin
    link_ok = found_a && found_b && (key_a != key_b) && (pin_a < kind_outputs(kind_a))
              && (pin_b < kind_inputs(kind_b));
    eff_idx = (state == S_CUR_PR) ? cur : idx[IDX_W-1:0];
    row_eff = link_rdata;
    if (ovr && eff_idx == ovr_node) begin
      for (int p = 0; p < PIN_SLOTS; p++) begin
        if (ovr_pin == PIN_W'(p)) begin
          row_eff[p] = '{vld: 1'b1, src: ovr_src, chan: ovr_chan};
        end
      end
    end
    row_new = link_rdata;
    for (int p = 0; p < PIN_SLOTS; p++) begin
      if (pin_b == PIN_W'(p)) begin
        row_new[p] = '{vld: 1'b1, src: idx_a, chan: pin_a};
      end
    end
    deg_cnt   = '0;
    match_cnt = '0;
    for (int p = 0; p < PIN_SLOTS; p++) begin
      deg_cnt   = deg_cnt + DEG_W'(row_eff[p].vld);
      match_cnt = match_cnt + DEG_W'(row_eff[p].vld && row_eff[p].src == cur);
    end
    deg_left = deg_rdata - match_cnt;
    cur_slot = slot_at(row, pin);

    node_we    = 1'b0;
    node_waddr = loaded[IDX_W-1:0];
    node_wdata = '{id: key_a, kind: new_kind};
    node_raddr = idx[IDX_W-1:0];
    link_we    = 1'b0;
    link_waddr = loaded[IDX_W-1:0];
    link_wdata = '0;
    link_raddr = idx[IDX_W-1:0];
    deg_we     = 1'b0;
    deg_waddr  = idx[IDX_W-1:0];
    deg_wdata  = deg_cnt;
    deg_raddr  = idx[IDX_W-1:0];
    wid_we     = 1'b0;
    wid_waddr  = idx[IDX_W-1:0];
    wid_wdata  = WID_SCALAR;
    wid_raddr  = cur_slot.src;
    que_we     = 1'b0;
    que_waddr  = tail[IDX_W-1:0];
    que_wdata  = idx[IDX_W-1:0];
    que_raddr  = head[IDX_W-1:0];

    case (state)
      S_NODE_END: begin
        node_we = !found_a;
        link_we = !found_a;
      end
      S_LINK_CHK: begin
        link_raddr = idx_b;
      end
      S_LINK_WR: begin
        link_we    = !slot_at(link_rdata, pin_b).vld;
        link_waddr = idx_b;
        link_wdata = row_new;
      end
      S_INIT_PR: begin
        deg_we = 1'b1;
        wid_we = 1'b1;
        que_we = (deg_cnt == '0);
      end
      S_CUR_RD: begin
        node_raddr = cur;
        link_raddr = cur;
      end
      S_CUR_PR: begin
        wid_waddr = cur;
        if (node_rdata.kind == KIND_TEXTURE || node_rdata.kind == KIND_COLOR) begin
          wid_we    = 1'b1;
          wid_wdata = WID_COLOR;
        end else if (node_rdata.kind == KIND_TEXCOORD) begin
          wid_we    = 1'b1;
          wid_wdata = WID_COORD;
        end
      end
      S_W_SL: begin
        wid_waddr = cur;
        wid_wdata = wacc;
        wid_we    = (pin == PIN_W'(PIN_SLOTS));
      end
      S_SCAN_PR: begin
        deg_wdata = deg_left;
        deg_we    = (match_cnt != '0);
        que_we    = (match_cnt != '0) && (deg_left == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rep_enable   <= 1'b0;
      rep_from_id  <= '0;
      rep_from_pin <= '0;
      rep_to_id    <= '0;
      rep_to_pin   <= '0;
      loaded       <= '0;
      ferr         <= ERR_NONE;
      ovr          <= 1'b0;
      head         <= '0;
      tail         <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_REP_ENABLE:   rep_enable   <= cfg_data[0];
          CFG_REP_FROM_ID:  rep_from_id  <= cfg_data[ID_W-1:0];
          CFG_REP_FROM_PIN: rep_from_pin <= cfg_data[PIN_W-1:0];
          CFG_REP_TO_ID:    rep_to_id    <= cfg_data[ID_W-1:0];
          CFG_REP_TO_PIN:   rep_to_pin   <= cfg_data[PIN_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid && result.ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            opcode   <= cmd.command;
            new_kind <= cmd.node_kind;
            idx      <= '0;
            found_a  <= 1'b0;
            found_b  <= 1'b0;
            done     <= 1'b0;
            ovr      <= 1'b0;
            head     <= '0;
            tail     <= '0;
            case (cmd.command)
              CMD_CLEAR: begin
                loaded <= '0;
                ferr   <= ERR_NONE;
                state  <= S_RESP;
              end
              CMD_NODE: begin
                key_a <= cmd.node_id;
                key_b <= cmd.node_id;
                if (loaded >= CNT_W'(NODE_CAP)) begin
                  ferr  <= ERR_TOO_MANY;
                  state <= S_RESP;
                end else if (cmd.node_id == '0 || cmd.node_kind >= KIND_W'(KIND_COUNT)) begin
                  if (ferr == ERR_NONE) ferr <= ERR_BAD_NODE;
                  state <= S_RESP;
                end else begin
                  state <= S_SRCH_RD;
                end
              end
              CMD_LINK: begin
                key_a <= cmd.link_from_id;
                key_b <= cmd.link_to_id;
                pin_a <= cmd.link_from_pin;
                pin_b <= cmd.link_to_pin;
                if (rep_enable && cmd.link_to_id == rep_to_id
                    && cmd.link_to_pin == rep_to_pin) begin
                  state <= S_RESP;
                end else begin
                  state <= S_SRCH_RD;
                end
              end
              default: begin
                done  <= 1'b1;
                key_a <= rep_from_id;
                key_b <= rep_to_id;
                pin_a <= rep_from_pin;
                pin_b <= rep_to_pin;
                if (ferr != ERR_NONE) begin
                  state <= S_RESP;
                end else if (rep_enable) begin
                  state <= S_SRCH_RD;
                end else begin
                  state <= S_INIT_RD;
                end
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if (idx == loaded) begin
            idx <= '0;
            case (opcode)
              CMD_NODE: state <= S_NODE_END;
              CMD_LINK: state <= S_LINK_CHK;
              default:  state <= S_REP_CHK;
            endcase
          end else begin
            state <= S_SRCH_CMP;
          end
        end
        S_SRCH_CMP: begin
          if (node_rdata.id == key_a) begin
            found_a <= 1'b1;
            idx_a   <= idx[IDX_W-1:0];
            kind_a  <= node_rdata.kind;
          end
          if (node_rdata.id == key_b) begin
            found_b <= 1'b1;
            idx_b   <= idx[IDX_W-1:0];
            kind_b  <= node_rdata.kind;
          end
          idx   <= idx + 1'b1;
          state <= S_SRCH_RD;
        end
        S_NODE_END: begin
          if (found_a) begin
            if (ferr == ERR_NONE) ferr <= ERR_BAD_NODE;
          end else begin
            loaded <= loaded + 1'b1;
          end
          state <= S_RESP;
        end
        S_LINK_CHK: begin
          if (link_ok) begin
            state <= S_LINK_WR;
          end else begin
            if (ferr == ERR_NONE) ferr <= ERR_BAD_LINK;
            state <= S_RESP;
          end
        end
        S_LINK_WR: begin
          if (slot_at(link_rdata, pin_b).vld && ferr == ERR_NONE) begin
            ferr <= ERR_BAD_LINK;
          end
          state <= S_RESP;
        end
        S_REP_CHK: begin
          if (link_ok) begin
            ovr      <= 1'b1;
            ovr_node <= idx_b;
            ovr_pin  <= pin_b;
            ovr_src  <= idx_a;
            ovr_chan <= pin_a;
            state    <= S_INIT_RD;
          end else begin
            ferr  <= ERR_BAD_LINK;
            state <= S_RESP;
          end
        end
        S_INIT_RD: begin
          state <= (idx == loaded) ? S_POP : S_INIT_PR;
        end
        S_INIT_PR: begin
          if (deg_cnt == '0) tail <= tail + 1'b1;
          idx   <= idx + 1'b1;
          state <= S_INIT_RD;
        end
        S_POP: begin
          if (head == tail) begin
            idx <= '0;
            if (tail != loaded) begin
              ferr  <= ERR_CYCLE;
              state <= S_RESP;
            end else begin
              state <= S_CHK_RD;
            end
          end else begin
            head  <= head + 1'b1;
            state <= S_POP_W;
          end
        end
        S_POP_W: begin
          cur   <= que_rdata;
          state <= S_CUR_RD;
        end
        S_CUR_RD: begin
          state <= S_CUR_PR;
        end
        S_CUR_PR: begin
          row  <= row_eff;
          pin  <= '0;
          wacc <= WID_SCALAR;
          idx  <= '0;
          if (node_rdata.kind == KIND_TEXTURE || node_rdata.kind == KIND_COLOR
              || node_rdata.kind == KIND_TEXCOORD) begin
            state <= S_SCAN_RD;
          end else begin
            state <= S_W_SL;
          end
        end
        S_W_SL: begin
          if (pin == PIN_W'(PIN_SLOTS)) begin
            state <= S_SCAN_RD;
          end else if (cur_slot.vld && cur_slot.chan == '0) begin
            state <= S_W_AC;
          end else begin
            pin <= pin + 1'b1;
          end
        end
        S_W_AC: begin
          if (wid_rdata > wacc) wacc <= wid_rdata;
          pin   <= pin + 1'b1;
          state <= S_W_SL;
        end
        S_SCAN_RD: begin
          state <= (idx == loaded) ? S_POP : S_SCAN_PR;
        end
        S_SCAN_PR: begin
          if (match_cnt != '0 && deg_left == '0) tail <= tail + 1'b1;
          idx   <= idx + 1'b1;
          state <= S_SCAN_RD;
        end
        S_CHK_RD: begin
          state <= (idx == loaded) ? S_RESP : S_CHK_LD;
        end
        S_CHK_LD: begin
          cur_kind <= node_rdata.kind;
          row      <= row_eff;
          pin      <= '0;
          state    <= S_C_SL;
        end
        S_C_SL: begin
          if (pin == PIN_W'(PIN_SLOTS)) begin
            idx   <= idx + 1'b1;
            state <= S_CHK_RD;
          end else if (!cur_slot.vld) begin
            pin <= pin + 1'b1;
          end else if (cur_slot.chan != '0) begin
            if (!pin_ok(cur_kind, pin, WID_SCALAR)) begin
              ferr  <= ERR_MISMATCH;
              state <= S_RESP;
            end else begin
              pin <= pin + 1'b1;
            end
          end else begin
            state <= S_C_AC;
          end
        end
        S_C_AC: begin
          if (!pin_ok(cur_kind, pin, wid_rdata)) begin
            ferr  <= ERR_MISMATCH;
            state <= S_RESP;
          end else begin
            pin   <= pin + 1'b1;
            state <= S_C_SL;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_done  <= done;
            out_gv    <= (ferr == ERR_NONE);
            out_err   <= ferr;
            out_total <= TOTAL_W'(loaded);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_node_bound: assert property (@(posedge clk) disable iff (rst)
    loaded <= CNT_W'(NODE_CAP))
    else $error("node count over table size");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("second transaction taken while busy");
  a_err_range: assert property (@(posedge clk) disable iff (rst) ferr <= ERR_MISMATCH)
    else $error("error code out of range");
endmodule
